// ----- rtl/handle_sparse_byte_store_core_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the sparse byte store RTL.
// ----------------------------------------------------------------------------
`ifndef HANDLE_SPARSE_BYTE_STORE_CORE_ASSERT_SVH
`define HANDLE_SPARSE_BYTE_STORE_CORE_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define HSBS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("hsbs: assertion failed");

// Condition that must never be true outside reset.
`define HSBS_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  `HSBS_ASSERT(lbl, clk, rst_n, !(cond))

`endif

// ----- rtl/hsbs_pkg.sv -----
// ----------------------------------------------------------------------------
// hsbs_pkg
// Sizes, request codes and shared types of the sparse byte store.
// ----------------------------------------------------------------------------
package hsbs_pkg;

  // Table and region dimensions.
  localparam int NUM_REGIONS = 8;
  localparam int NUM_SLOTS   = 64;
  localparam int OFFSET_BITS = 24;

  // Handles are three bits wide, so at most eight regions are reachable.
  localparam int HANDLE_W   = 3;
  localparam int HANDLE_CNT = (NUM_REGIONS < (1 << HANDLE_W)) ? NUM_REGIONS : (1 << HANDLE_W);
  localparam int REGION_IW  = (HANDLE_CNT > 1) ? $clog2(HANDLE_CNT) : 1;
  localparam int SLOT_IW    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int SIZE_W     = OFFSET_BITS + 1;
  localparam int DATA_W     = 16;
  localparam int REQ_W      = 3;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_ALLOC   = 3'd0;
  localparam logic [REQ_W-1:0] REQ_FREE    = 3'd1;
  localparam logic [REQ_W-1:0] REQ_READ8   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_WRITE8  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_READ16  = 3'd4;
  localparam logic [REQ_W-1:0] REQ_WRITE16 = 3'd5;

  // One entry of the byte slot table.
  typedef struct packed {
    logic [HANDLE_W-1:0]    owner;
    logic [OFFSET_BITS-1:0] offset;
    logic [7:0]             data;
  } slot_entry_t;

  // Commands from the sequencer to the region table.
  typedef struct packed {
    logic              alloc;
    logic              drop;
    logic [SIZE_W-1:0] size;
  } region_cmd_t;

  // Status from the region table to the sequencer.
  typedef struct packed {
    logic                alloc_ok;
    logic [HANDLE_W-1:0] alloc_handle;
    logic                handle_ok;
    logic                access_ok;
  } region_sts_t;

endpackage

// ----- rtl/hsbs_ifs.sv -----
// ----------------------------------------------------------------------------
// hsbs request and response interfaces
// Valid/ready channels carrying request and response beats.
// ----------------------------------------------------------------------------
interface hsbs_req_if;
  import hsbs_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [REQ_W-1:0]       req_type;
  logic [HANDLE_W-1:0]    handle;
  logic [OFFSET_BITS-1:0] offset;
  logic [SIZE_W-1:0]      alloc_size;
  logic [DATA_W-1:0]      write_data;

  modport source (
    output valid, req_type, handle, offset, alloc_size, write_data,
    input  ready
  );
  modport sink (
    input  valid, req_type, handle, offset, alloc_size, write_data,
    output ready
  );
endinterface

interface hsbs_rsp_if;
  import hsbs_pkg::*;

  logic                valid;
  logic                ready;
  logic                ok;
  logic [HANDLE_W-1:0] granted_handle;
  logic [DATA_W-1:0]   read_data;

  modport source (
    output valid, ok, granted_handle, read_data,
    input  ready
  );
  modport sink (
    input  valid, ok, granted_handle, read_data,
    output ready
  );
endinterface

// ----- rtl/hsbs_ram.sv -----
// ----------------------------------------------------------------------------
// hsbs_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module hsbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/hsbs_regions.sv -----
// ----------------------------------------------------------------------------
// hsbs_regions
// Region table: in-use flags and sizes, lowest-free allocation, access checks.
// ----------------------------------------------------------------------------
module hsbs_regions (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  hsbs_pkg::region_cmd_t         cmd_i,
  input  logic [hsbs_pkg::HANDLE_W-1:0] qry_handle_i,
  input  logic [hsbs_pkg::SIZE_W-1:0]   qry_addr_i,
  output hsbs_pkg::region_sts_t         sts_o
);
  import hsbs_pkg::*;

  localparam logic [SIZE_W-1:0] SIZE_LIMIT = SIZE_W'(1) << OFFSET_BITS;

  logic [HANDLE_CNT-1:0] in_use_q, in_use_d;
  logic [SIZE_W-1:0]     size_q [HANDLE_CNT];

  logic                 free_found;
  logic [HANDLE_W-1:0]  free_handle;
  logic                 in_range;
  logic [REGION_IW-1:0] qry_idx;
  logic [REGION_IW-1:0] alloc_idx;
  logic [SIZE_W-1:0]    sat_size;

  // Lowest handle that is not in use.
  always_comb begin
    free_found  = 1'b0;
    free_handle = '0;
    for (int i = HANDLE_CNT - 1; i >= 0; i--) begin
      if (!in_use_q[i]) begin
        free_found  = 1'b1;
        free_handle = HANDLE_W'(i);
      end
    end
  end

  assign alloc_idx = free_handle[REGION_IW-1:0];
  assign qry_idx   = qry_handle_i[REGION_IW-1:0];
  assign in_range  = (32'(qry_handle_i) < HANDLE_CNT);
  assign sat_size  = (cmd_i.size > SIZE_LIMIT) ? SIZE_LIMIT : cmd_i.size;

  // Status toward the sequencer.
  always_comb begin
    sts_o.alloc_ok     = free_found;
    sts_o.alloc_handle = free_found ? free_handle : '0;
    sts_o.handle_ok    = in_range && in_use_q[qry_idx];
    sts_o.access_ok    = in_range && in_use_q[qry_idx] && (qry_addr_i < size_q[qry_idx]);
  end

  // In-use flag updates.
  always_comb begin
    in_use_d = in_use_q;
    if (cmd_i.alloc && free_found) begin
      in_use_d[alloc_idx] = 1'b1;
    end
    if (cmd_i.drop && in_range) begin
      in_use_d[qry_idx] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_use_q <= '0;
    end else begin
      in_use_q <= in_use_d;
    end
  end

  // Region sizes are only looked at while the region is in use.
  always_ff @(posedge clk_i) begin
    if (cmd_i.alloc && free_found) begin
      size_q[alloc_idx] <= sat_size;
    end
  end

endmodule

// ----- rtl/handle_sparse_byte_store_core.sv -----
// ----------------------------------------------------------------------------
// handle_sparse_byte_store_core
// Handle-based sparse byte memory with a scanned byte slot table.
// ----------------------------------------------------------------------------
// Requests arrive one beat at a time on req_i and each gives one beat on
// rsp_o. Alloc, failed checks and unknown requests go from dispatch straight
// to the response state. A byte read or write scans the slot table in a RAM
// with one read port, one slot per cycle; a match ends the scan early. Free
// scans the whole table to drop the handle's bytes. 16-bit accesses run two
// byte scans. The next request beat is taken in the same cycle that the
// response is offered, as soon as the sequencer is idle, while that response
// may still wait in the output register.
`include "handle_sparse_byte_store_core_assert.svh"

module handle_sparse_byte_store_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  hsbs_req_if.sink    req_i,
  hsbs_rsp_if.source  rsp_o
);
  import hsbs_pkg::*;

  // Sequencer states.
  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_DISPATCH = 3'd1;
  localparam logic [2:0] ST_SCAN     = 3'd2;
  localparam logic [2:0] ST_RESOLVE  = 3'd3;
  localparam logic [2:0] ST_RESP     = 3'd4;

  localparam logic [SLOT_IW-1:0] LAST_SLOT = SLOT_IW'(NUM_SLOTS - 1);

  logic [2:0] state_q, state_d;

  // Latched request.
  logic [REQ_W-1:0]    req_type_q, req_type_d;
  logic [HANDLE_W-1:0] handle_q, handle_d;
  logic [SIZE_W-1:0]   addr_q, addr_d;
  logic [SIZE_W-1:0]   size_q, size_d;
  logic [DATA_W-1:0]   wdata_q, wdata_d;
  logic                phase_q, phase_d;
  logic [7:0]          lo_byte_q, lo_byte_d;

  // Scan engine.
  logic               issue_q, issue_d;
  logic [SLOT_IW-1:0] rd_idx_q, rd_idx_d;
  logic               cmp_vld_q, cmp_vld_d;
  logic [SLOT_IW-1:0] cmp_idx_q, cmp_idx_d;
  logic               match_q, match_d;
  logic [SLOT_IW-1:0] match_idx_q, match_idx_d;
  logic [7:0]         match_byte_q, match_byte_d;
  logic               free_q, free_d;
  logic [SLOT_IW-1:0] free_idx_q, free_idx_d;
  logic [NUM_SLOTS-1:0] slot_valid_q, slot_valid_d;

  // Pending result and output register.
  logic                res_ok_q, res_ok_d;
  logic [HANDLE_W-1:0] res_grant_q, res_grant_d;
  logic [DATA_W-1:0]   res_rd_q, res_rd_d;
  logic                out_valid_q, out_valid_d;
  logic                out_ok_q;
  logic [HANDLE_W-1:0] out_grant_q;
  logic [DATA_W-1:0]   out_rd_q;

  // RAM and region table connections.
  logic               ram_we;
  logic [SLOT_IW-1:0] ram_waddr;
  slot_entry_t        ram_wdata;
  logic               ram_re;
  slot_entry_t        ram_rdata;
  region_cmd_t        region_cmd;
  region_sts_t        region_sts;

  logic         req_fire;
  logic         out_free;
  logic         owner_hit;
  logic         lookup_hit;
  logic         is_write;
  logic         is_wide;
  logic         can_write;
  logic [7:0]   byte_val;
  logic [7:0]   wr_byte;
  logic [SLOT_IW-1:0] wr_target;

  assign req_fire    = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == ST_IDLE);
  assign out_free    = !out_valid_q || rsp_o.ready;

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.ok             = out_ok_q;
  assign rsp_o.granted_handle = out_grant_q;
  assign rsp_o.read_data      = out_rd_q;

  // Slot byte table.
  hsbs_ram #(
    .WIDTH ($bits(slot_entry_t)),
    .DEPTH (NUM_SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (rd_idx_q),
    .rdata_o (ram_rdata)
  );

  // Region flags, sizes and checks.
  hsbs_regions u_regions (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (region_cmd),
    .qry_handle_i (handle_q),
    .qry_addr_i   (addr_q),
    .sts_o        (region_sts)
  );

  // Compare of the slot read in the previous cycle.
  assign owner_hit  = cmp_vld_q && slot_valid_q[cmp_idx_q] && (ram_rdata.owner == handle_q);
  assign lookup_hit = owner_hit && ({1'b0, ram_rdata.offset} == addr_q);

  assign is_write  = (req_type_q == REQ_WRITE8) || (req_type_q == REQ_WRITE16);
  assign is_wide   = (req_type_q == REQ_READ16) || (req_type_q == REQ_WRITE16);
  assign byte_val  = match_q ? match_byte_q : 8'h00;
  assign wr_byte   = phase_q ? wdata_q[15:8] : wdata_q[7:0];
  assign wr_target = match_q ? match_idx_q : free_idx_q;
  assign can_write = match_q || free_q;
  assign ram_re    = (state_q == ST_SCAN) && issue_q;

  // Sequencer.
  always_comb begin
    state_d      = state_q;
    req_type_d   = req_type_q;
    handle_d     = handle_q;
    addr_d       = addr_q;
    size_d       = size_q;
    wdata_d      = wdata_q;
    phase_d      = phase_q;
    lo_byte_d    = lo_byte_q;
    issue_d      = issue_q;
    rd_idx_d     = rd_idx_q;
    cmp_vld_d    = 1'b0;
    cmp_idx_d    = cmp_idx_q;
    match_d      = match_q;
    match_idx_d  = match_idx_q;
    match_byte_d = match_byte_q;
    free_d       = free_q;
    free_idx_d   = free_idx_q;
    slot_valid_d = slot_valid_q;
    res_ok_d     = res_ok_q;
    res_grant_d  = res_grant_q;
    res_rd_d     = res_rd_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    ram_we       = 1'b0;
    ram_waddr    = wr_target;
    ram_wdata.owner  = handle_q;
    ram_wdata.offset = addr_q[OFFSET_BITS-1:0];
    ram_wdata.data   = wr_byte;
    region_cmd.alloc = 1'b0;
    region_cmd.drop  = 1'b0;
    region_cmd.size  = size_q;

    unique case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          req_type_d = req_i.req_type;
          handle_d   = req_i.handle;
          addr_d     = {1'b0, req_i.offset};
          size_d     = req_i.alloc_size;
          wdata_d    = req_i.write_data;
          phase_d    = 1'b0;
          state_d    = ST_DISPATCH;
        end
      end

      ST_DISPATCH: begin
        // Default to a failed response; scans override below.
        res_ok_d    = 1'b0;
        res_grant_d = '0;
        res_rd_d    = '0;
        state_d     = ST_RESP;
        issue_d     = 1'b1;
        rd_idx_d    = '0;
        match_d     = 1'b0;
        free_d      = 1'b0;
        unique case (req_type_q)
          REQ_ALLOC: begin
            region_cmd.alloc = 1'b1;
            res_ok_d         = region_sts.alloc_ok;
            res_grant_d      = region_sts.alloc_handle;
          end
          REQ_FREE: begin
            if (region_sts.handle_ok) begin
              region_cmd.drop = 1'b1;
              state_d         = ST_SCAN;
            end
          end
          REQ_READ8, REQ_WRITE8, REQ_READ16, REQ_WRITE16: begin
            if (region_sts.access_ok) begin
              state_d = ST_SCAN;
            end
          end
          default: begin
            state_d = ST_RESP;
          end
        endcase
      end

      ST_SCAN: begin
        // Issue one slot read per cycle.
        if (issue_q) begin
          cmp_vld_d = 1'b1;
          cmp_idx_d = rd_idx_q;
          rd_idx_d  = rd_idx_q + SLOT_IW'(1);
          if (rd_idx_q == LAST_SLOT) begin
            issue_d = 1'b0;
          end
        end
        if (req_type_q == REQ_FREE) begin
          // Drop every slot owned by the freed handle.
          if (owner_hit) begin
            slot_valid_d[cmp_idx_q] = 1'b0;
          end
          if (cmp_vld_q && (cmp_idx_q == LAST_SLOT)) begin
            res_ok_d = 1'b1;
            state_d  = ST_RESP;
          end
        end else begin
          // Track the lowest empty slot in case no match turns up.
          if (cmp_vld_q && !slot_valid_q[cmp_idx_q] && !free_q) begin
            free_d     = 1'b1;
            free_idx_d = cmp_idx_q;
          end
          if (lookup_hit) begin
            match_d      = 1'b1;
            match_idx_d  = cmp_idx_q;
            match_byte_d = ram_rdata.data;
            state_d      = ST_RESOLVE;
          end else if (cmp_vld_q && (cmp_idx_q == LAST_SLOT)) begin
            state_d = ST_RESOLVE;
          end
        end
        if (state_d != ST_SCAN) begin
          cmp_vld_d = 1'b0;
        end
      end

      ST_RESOLVE: begin
        if (is_write) begin
          if (can_write) begin
            ram_we                  = 1'b1;
            slot_valid_d[wr_target] = 1'b1;
            if (is_wide && !phase_q) begin
              phase_d = 1'b1;
              addr_d  = addr_q + SIZE_W'(1);
              state_d = ST_DISPATCH;
            end else begin
              res_ok_d = 1'b1;
              state_d  = ST_RESP;
            end
          end else begin
            // Table full: a low byte already written stays.
            state_d = ST_RESP;
          end
        end else begin
          if (is_wide && !phase_q) begin
            lo_byte_d = byte_val;
            phase_d   = 1'b1;
            addr_d    = addr_q + SIZE_W'(1);
            state_d   = ST_DISPATCH;
          end else begin
            res_ok_d = 1'b1;
            res_rd_d = is_wide ? {byte_val, lo_byte_q} : {8'h00, byte_val};
            state_d  = ST_RESP;
          end
        end
      end

      ST_RESP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      issue_q      <= 1'b0;
      cmp_vld_q    <= 1'b0;
      slot_valid_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      issue_q      <= issue_d;
      cmp_vld_q    <= cmp_vld_d;
      slot_valid_q <= slot_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    req_type_q   <= req_type_d;
    handle_q     <= handle_d;
    addr_q       <= addr_d;
    size_q       <= size_d;
    wdata_q      <= wdata_d;
    phase_q      <= phase_d;
    lo_byte_q    <= lo_byte_d;
    rd_idx_q     <= rd_idx_d;
    cmp_idx_q    <= cmp_idx_d;
    match_q      <= match_d;
    match_idx_q  <= match_idx_d;
    match_byte_q <= match_byte_d;
    free_q       <= free_d;
    free_idx_q   <= free_idx_d;
    res_ok_q     <= res_ok_d;
    res_grant_q  <= res_grant_d;
    res_rd_q     <= res_rd_d;
    if ((state_q == ST_RESP) && out_free) begin
      out_ok_q    <= res_ok_q;
      out_grant_q <= res_grant_q;
      out_rd_q    <= res_rd_q;
    end
  end

  // A written slot is marked valid right after the table write.
  `HSBS_ASSERT(a_write_sets_valid, clk_i, rst_ni, ram_we |=> slot_valid_q[$past(ram_waddr)])
  // An accepted beat always moves the sequencer into dispatch.
  `HSBS_ASSERT(a_accept_dispatch, clk_i, rst_ni, req_fire |=> (state_q == ST_DISPATCH))
  // The last slot compare never sees another read still being issued.
  `HSBS_ASSERT_NEVER(a_scan_overrun, clk_i, rst_ni, cmp_vld_q && (cmp_idx_q == LAST_SLOT) && issue_q)
  // A response beat only appears out of the response state.
  `HSBS_ASSERT(a_resp_source, clk_i, rst_ni, $rose(out_valid_q) |-> ($past(state_q) == ST_RESP))

endmodule
